// ===== src/vlt_pkg.sv =====
// Package for the video line timing and interrupt block.
// Holds command codes, timing constants and the packed request layout.
// No dependencies.
package vlt_pkg;

  // Command codes carried in tuser
  localparam logic [1:0] CMD_RUN    = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam int unsigned CplW   = 10;
  localparam int unsigned AccW   = 16;
  localparam int unsigned LineW  = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [CplW-1:0]  CPL_RESET       = 10'd227;
  localparam logic [7:0]       UNDERFLOW_MARK  = 8'hFF;
  localparam logic [LineW-1:0] FRAME_LINE      = 9'd193;
  localparam logic [LineW-1:0] JUMP_LINE       = 9'd219;
  localparam logic [7:0]       JUMP_TARGET     = 8'd213;
  localparam logic [LineW-1:0] LINES_PER_FRAME = 9'd262;
  localparam logic [LineW-1:0] VISIBLE_LINES   = 9'd192;
  localparam logic [7:0]       STATUS_ONES     = 8'd31;

  // Register numbers with side effects
  localparam logic [3:0] REG_MODE0  = 4'd0;
  localparam logic [3:0] REG_MODE1  = 4'd1;
  localparam logic [3:0] REG_VSCROLL = 4'd9;
  localparam logic [3:0] REG_LINECNT = 4'd10;

  // One request as held in the input register
  typedef struct packed {
    logic       collision_event;
    logic       overflow_event;
    logic [7:0] reg_value;
    logic [3:0] reg_index;
    logic [7:0] cycle_count;
    logic [1:0] cmd;
  } req_t;

endpackage

// ===== src/video_line_timing_and_interrupts_top.sv =====
// Top level of the video line timing and interrupt block.
// Depends on vlt_pkg for command codes, constants and the request layout.
//
// Scanline timing and interrupt logic of a tile video chip. Each request on the
// slave stream is a command in tuser (0 run, 1 register write, 2 status read)
// with its operands in tdata; each request produces exactly one result on the
// master stream. A request is captured in an input register; when the result
// register can take it, all state (cycle accumulator, line and port counters,
// line down-counter, scroll latch, register file, pending flags) is updated by
// one short pass of logic whose outcome lands in the result register, which
// sits behind the input register. Throughput is one request per clock unless
// the result stream stalls. The input side keeps accepting while a result
// waits, until both registers are full. The user writes cycles_per_line through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
module video_line_timing_and_interrupts_top
  import vlt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: cycles_per_line
  input  logic                cfg_we_i,
  input  logic [CplW-1:0]     cfg_wdata_i,
  // request stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata, low bit up: cycle_count[7:0], reg_index[11:8], reg_value[19:12],
  // overflow_event[20], collision_event[21], zero fill[23:22]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]          s_axis_tuser_i,
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata, low bit up: irq[0], status_byte[8:1], line_done[9], frame_start[10],
  // line_number[19:11], counter_port[27:20], scroll_value[35:28], zero[39:36]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Handshake and pipeline control
  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic advance;

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Architectural state
  logic [CplW-1:0]  cpl_q;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [LineW-1:0] line_q, line_d;
  logic [7:0]       port_q, port_d;
  logic [7:0]       down_q, down_d;
  logic [7:0]       scroll_q, scroll_d;
  logic [7:0]       reg_q [16];
  logic             frame_pend_q, frame_pend_d;
  logic             line_pend_q, line_pend_d;
  logic             ovf_q, ovf_d;
  logic             col_q, col_d;

  // Per-request results
  logic [7:0]       status;
  logic             done;
  logic             frame;
  logic             irq;
  logic [AccW:0]    sum;
  logic [AccW-1:0]  acc_sat;
  logic [LineW-1:0] line_inc;
  logic [7:0]       down_dec;
  logic [7:0]       mode0, mode1;
  logic             reg_we;

  always_comb begin
    acc_d        = acc_q;
    line_d       = line_q;
    port_d       = port_q;
    down_d       = down_q;
    scroll_d     = scroll_q;
    frame_pend_d = frame_pend_q;
    line_pend_d  = line_pend_q;
    // sprite events land before the command so a status read sees them
    ovf_d        = ovf_q | req_q.overflow_event;
    col_d        = col_q | req_q.collision_event;
    status       = '0;
    done         = 1'b0;
    frame        = 1'b0;
    reg_we       = 1'b0;

    // saturating cycle accumulation
    sum      = {1'b0, acc_q} + {{(AccW + 1 - 8){1'b0}}, req_q.cycle_count};
    acc_sat  = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    line_inc = line_q + 1'b1;
    down_dec = down_q - 1'b1;

    case (req_q.cmd)
      CMD_RUN: begin
        acc_d = acc_sat;
        if (acc_sat >= {{(AccW - CplW){1'b0}}, cpl_q}) begin
          acc_d = acc_sat - {{(AccW - CplW){1'b0}}, cpl_q};
          done  = 1'b1;
          // line down-counter only runs on visible lines
          if (line_q < VISIBLE_LINES) begin
            down_d = down_dec;
            if (down_dec == UNDERFLOW_MARK) begin
              line_pend_d = 1'b1;
              down_d      = reg_q[REG_LINECNT];
            end
          end
          line_d = line_inc;
          port_d = port_q + 1'b1;
          if (line_inc == FRAME_LINE) begin
            frame_pend_d = 1'b1;
            scroll_d     = reg_q[REG_VSCROLL];
            down_d       = reg_q[REG_LINECNT];
            frame        = 1'b1;
          end else if (line_inc == JUMP_LINE) begin
            port_d = JUMP_TARGET;
          end else if (line_inc >= LINES_PER_FRAME) begin
            line_d = '0;
            port_d = '0;
          end
        end
      end
      CMD_WRITE: begin
        reg_we = 1'b1;
        // blanking writes take effect at once
        if (line_q >= VISIBLE_LINES) begin
          if (req_q.reg_index == REG_VSCROLL) scroll_d = req_q.reg_value;
          if (req_q.reg_index == REG_LINECNT) down_d = req_q.reg_value;
        end
      end
      CMD_STATUS: begin
        status       = STATUS_ONES | {frame_pend_q, ovf_d, col_d, 5'd0};
        frame_pend_d = 1'b0;
        line_pend_d  = 1'b0;
        ovf_d        = 1'b0;
        col_d        = 1'b0;
      end
      default: begin
        // unused command: no state change beyond the event flags
      end
    endcase

    // interrupt enables as they stand after this request's write
    mode0 = (reg_we && req_q.reg_index == REG_MODE0) ? req_q.reg_value : reg_q[REG_MODE0];
    mode1 = (reg_we && req_q.reg_index == REG_MODE1) ? req_q.reg_value : reg_q[REG_MODE1];
    irq   = (frame_pend_d & mode1[5]) | (line_pend_d & mode0[4]);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q <= '{collision_event: s_axis_tdata_i[21],
                 overflow_event:  s_axis_tdata_i[20],
                 reg_value:       s_axis_tdata_i[19:12],
                 reg_index:       s_axis_tdata_i[11:8],
                 cycle_count:     s_axis_tdata_i[7:0],
                 cmd:             s_axis_tuser_i};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {4'd0, scroll_d, port_d, line_d, frame, done, status, irq};
    end
  end

  // State update, one request per advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q        <= CPL_RESET;
      acc_q        <= '0;
      line_q       <= '0;
      port_q       <= '0;
      down_q       <= '0;
      scroll_q     <= '0;
      frame_pend_q <= 1'b0;
      line_pend_q  <= 1'b0;
      ovf_q        <= 1'b0;
      col_q        <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        reg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cpl_q <= cfg_wdata_i;
      end
      if (advance) begin
        acc_q        <= acc_d;
        line_q       <= line_d;
        port_q       <= port_d;
        down_q       <= down_d;
        scroll_q     <= scroll_d;
        frame_pend_q <= frame_pend_d;
        line_pend_q  <= line_pend_d;
        ovf_q        <= ovf_d;
        col_q        <= col_d;
        if (reg_we) begin
          reg_q[req_q.reg_index] <= req_q.reg_value;
        end
      end
    end
  end

endmodule

// ===== sim/video_line_timing_and_interrupts_checker.sv =====
// Checker for the video line timing and interrupt block: predicts each result from
// the accepted requests and compares it with the result stream.
// Depends on vlt_pkg for command codes, register numbers and timing constants.
module video_line_timing_and_interrupts_checker
  import vlt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CplW-1:0]     cfg_wdata_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic [1:0]          s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Result layout, lowest field last
  typedef struct packed {
    logic [7:0]       scroll;
    logic [7:0]       vcount;
    logic [LineW-1:0] line;
    logic             frame;
    logic             done;
    logic [7:0]       status;
    logic             irq;
  } timing_result_t;

  logic [CplW-1:0]  line_len;
  logic [AccW-1:0]  acc;
  logic [LineW-1:0] line_cnt;
  logic [7:0]       vcount;
  logic [7:0]       down_cnt;
  logic [7:0]       scroll_q;
  logic [7:0]       regs [16];
  logic             frame_pend;
  logic             line_pend;
  logic             ovf_flag;
  logic             col_flag;

  timing_result_t expected_results [$];

  // Applies one request to the predicted state and returns its result
  task automatic step_timing(input logic [1:0] cmd, input logic [InDataW-1:0] data,
                             output timing_result_t r);
    int unsigned sum;
    logic [7:0]  cycles;
    logic [3:0]  idx;
    logic [7:0]  val;
    cycles = data[7:0];
    idx    = data[11:8];
    val    = data[19:12];
    r      = '0;
    // sprite events land before the command
    if (data[20]) ovf_flag = 1'b1;
    if (data[21]) col_flag = 1'b1;
    case (cmd)
      CMD_RUN: begin
        sum = acc + cycles;
        if (sum > 32'hFFFF) sum = 32'hFFFF;
        acc = sum[AccW-1:0];
        if (acc >= line_len) begin
          acc    = acc - line_len;
          r.done = 1'b1;
          if (line_cnt < VISIBLE_LINES) begin
            down_cnt = down_cnt - 8'd1;
            if (down_cnt == UNDERFLOW_MARK) begin
              line_pend = 1'b1;
              down_cnt  = regs[REG_LINECNT];
            end
          end
          line_cnt = line_cnt + 9'd1;
          vcount   = vcount + 8'd1;
          if (line_cnt == FRAME_LINE) begin
            frame_pend = 1'b1;
            scroll_q   = regs[REG_VSCROLL];
            down_cnt   = regs[REG_LINECNT];
            r.frame    = 1'b1;
          end else if (line_cnt == JUMP_LINE) begin
            vcount = JUMP_TARGET;
          end else if (line_cnt >= LINES_PER_FRAME) begin
            line_cnt = '0;
            vcount   = '0;
          end
        end
      end
      CMD_WRITE: begin
        // blanking: scroll and counter reload take effect at once
        if (idx == REG_VSCROLL && line_cnt >= VISIBLE_LINES) scroll_q = val;
        if (idx == REG_LINECNT && line_cnt >= VISIBLE_LINES) down_cnt = val;
        regs[idx] = val;
      end
      CMD_STATUS: begin
        r.status   = STATUS_ONES | {frame_pend, ovf_flag, col_flag, 5'b0};
        frame_pend = 1'b0;
        line_pend  = 1'b0;
        ovf_flag   = 1'b0;
        col_flag   = 1'b0;
      end
      default: ;
    endcase
    r.irq    = (frame_pend && regs[REG_MODE1][5]) || (line_pend && regs[REG_MODE0][4]);
    r.line   = line_cnt;
    r.vcount = vcount;
    r.scroll = scroll_q;
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timing_result_t r;
    timing_result_t want;
    if (!rst_ni) begin
      line_len   = CPL_RESET;
      acc        = '0;
      line_cnt   = '0;
      vcount     = '0;
      down_cnt   = '0;
      scroll_q   = '0;
      frame_pend = 1'b0;
      line_pend  = 1'b0;
      ovf_flag   = 1'b0;
      col_flag   = 1'b0;
      foreach (regs[i]) regs[i] = '0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) line_len = cfg_wdata_i;
      if (s_valid_i && s_ready_i) begin
        step_timing(s_user_i, s_data_i, r);
        expected_results.push_back(r);
      end
      if (m_valid_i && m_ready_i) begin
        r = m_data_i[$bits(timing_result_t)-1:0];
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request outstanding, expected none, got 0x%0h",
                   $time, r);
        end else begin
          want = expected_results.pop_front();
          compare_field("irq", want.irq, r.irq);
          compare_field("status_byte", want.status, r.status);
          compare_field("line_done", want.done, r.done);
          compare_field("frame_start", want.frame, r.frame);
          compare_field("line_number", want.line, r.line);
          compare_field("counter_port", want.vcount, r.vcount);
          compare_field("scroll_value", want.scroll, r.scroll);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== sim/video_line_timing_and_interrupts_top_tb.sv =====
// Testbench top for the video line timing and interrupt block: drives requests,
// line length settings and result backpressure, and reports the verdict.
// Depends on vlt_pkg, the block top and video_line_timing_and_interrupts_checker.
module video_line_timing_and_interrupts_top_tb;
  import vlt_pkg::*;

  // cmd value the block must ignore apart from the sprite events
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // generous bound for a correct run
  localparam int CYCLE_LIMIT = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CplW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [1:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int cycles_run = 0;
  // when set, neither side inserts gaps: back-to-back requests and results
  bit steady_flow;

  video_line_timing_and_interrupts_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  video_line_timing_and_interrupts_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_i   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .m_valid_i   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_i    (m_axis_tdata_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    if (cycles_run == CYCLE_LIMIT) begin
      $display("FAIL video_line_timing_and_interrupts_top");
      $finish;
    end
    cycles_run++;
  end

  // Presents one request after a random gap and holds it until accepted.
  // valid stays high across back-to-back requests; it is only lowered when a
  // gap follows, so it never gets two updates in one step.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] cycles,
                              input logic [3:0] idx, input logic [7:0] val,
                              input logic ovf, input logic col);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    // tdata: cycle_count, reg_index, reg_value, overflow, collision, zero fill
    s_axis_tdata_i  <= {2'b00, col, ovf, val, idx, cycles};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Every request yields one result, so an empty expectation queue means the
  // block is idle. pending is read on the falling edge, away from the checker.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_line_length(input logic [CplW-1:0] len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly run commands so the line counter sweeps whole frames; writes favor
  // the enable, scroll and line counter registers, reload values are mostly small so
  // line interrupts come often. heavy pushes cycle counts to the top to drive
  // the accumulator into saturation.
  task automatic send_random_request(input bit heavy);
    int         pick;
    logic [1:0] cmd;
    logic [7:0] cycles;
    logic [3:0] idx;
    logic [7:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 70) cmd = CMD_RUN;
    else if (pick < 89) cmd = CMD_WRITE;
    else if (pick < 99) cmd = CMD_STATUS;
    else cmd = CMD_UNUSED;
    if (heavy && $urandom_range(0, 7) != 0) cycles = 8'hFF;
    else cycles = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: idx = REG_MODE0;
      1: idx = REG_MODE1;
      2: idx = REG_VSCROLL;
      3: idx = REG_LINECNT;
      default: idx = 4'($urandom_range(0, 15));
    endcase
    if (idx == REG_LINECNT && $urandom_range(0, 3) != 0) val = 8'($urandom_range(0, 7));
    else val = 8'($urandom_range(0, 255));
    send_request(cmd, cycles, idx, val, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 7) == 0);
  endtask

  task automatic run_phase(input logic [CplW-1:0] len, input int count, input bit heavy);
    set_line_length(len);
    for (int n = 0; n < count; n++) begin
      // alternate stretches of random gaps with gap-free stretches
      if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_random_request(heavy);
    end
  endtask

  // Result side: random stall per result, none during steady stretches
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_RUN;
    steady_flow     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, line length at its reset value of 227.
    // Enable both interrupts, reload zero so every visible line underflows.
    send_request(CMD_WRITE, 8'd0, REG_MODE0, 8'h10, 1'b0, 1'b0);
    send_request(CMD_WRITE, 8'd0, REG_MODE1, 8'h20, 1'b0, 1'b0);
    send_request(CMD_WRITE, 8'd0, REG_LINECNT, 8'h00, 1'b0, 1'b0);
    // visible line: scroll write is stored only, not latched
    send_request(CMD_WRITE, 8'd0, REG_VSCROLL, 8'hFF, 1'b0, 1'b0);
    // a full-size run completes a line, counter wraps, line interrupt rises
    send_request(CMD_RUN, 8'hFF, 4'd0, 8'd0, 1'b0, 1'b0);
    send_request(CMD_RUN, 8'h00, 4'd0, 8'd0, 1'b0, 1'b0);
    // events in the same step as a status read are reported and cleared
    send_request(CMD_STATUS, 8'd0, 4'd0, 8'd0, 1'b1, 1'b1);
    // unused command still sets the event flags and yields a result
    send_request(CMD_UNUSED, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1);
    send_request(CMD_STATUS, 8'd0, 4'd0, 8'd0, 1'b0, 1'b0);
    send_request(CMD_WRITE, 8'd0, 4'hF, 8'hFF, 1'b0, 1'b0);
    // accumulator lands exactly on the line length
    send_request(CMD_RUN, 8'd199, 4'd0, 8'd0, 1'b0, 1'b0);

    // zero line length: every run completes a line, even with no cycles
    set_line_length('0);
    send_request(CMD_RUN, 8'h00, 4'd0, 8'd0, 1'b0, 1'b0);
    send_request(CMD_RUN, 8'h00, 4'd0, 8'd0, 1'b1, 1'b0);
    send_request(CMD_STATUS, 8'd0, 4'd0, 8'd0, 1'b0, 1'b1);

    // longest line: a full-size run falls short
    set_line_length(10'd1023);
    send_request(CMD_RUN, 8'hFF, 4'd0, 8'd0, 1'b0, 1'b0);
    send_request(CMD_RUN, 8'hFF, 4'd0, 8'd0, 1'b0, 1'b0);

    // Random part. The shortest line with near-full runs saturates the
    // accumulator and sweeps past the frame line, the jump line and the wrap.
    run_phase(10'd1, 420, 1'b1);
    run_phase(10'd1023, 120, 1'b0);
    run_phase(10'($urandom_range(2, 300)), 200, 1'b0);
    run_phase('0, 60, 1'b0);
    run_phase(CPL_RESET, 230, 1'b0);

    // drain, then let the block run on idle to show anything stray
    steady_flow = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS video_line_timing_and_interrupts_top");
    end else begin
      $display("FAIL video_line_timing_and_interrupts_top");
    end
    $finish;
  end

endmodule
